[hw/rtl/pspd_pkg.sv]
package pspd_pkg;

  // field widths
  localparam int unsigned COORD_W = 24;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned DIST_W  = 32;

  // shared datapath widths
  localparam int unsigned ACC_W    = 50;
  localparam int unsigned MPLIER_W = 24;
  localparam int unsigned ROOT_W   = 25;
  localparam int unsigned REM_W    = 27;
  localparam int unsigned CNT_W    = 5;

  // last count of each serial phase
  localparam logic [CNT_W-1:0] CNT_SQ_LAST    = 5'd23;
  localparam logic [CNT_W-1:0] CNT_ROOT_LAST  = 5'd24;
  localparam logic [CNT_W-1:0] CNT_MUL16_LAST = 5'd15;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_ACCEL     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_SPEED = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MAP_RES   = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] ACCEL_RST     = 16'd410;
  localparam logic [CFG_W-1:0] MAX_SPEED_RST = 16'd9011;
  localparam logic [CFG_W-1:0] MAP_RES_RST   = 16'd19661;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ROOT_LEN,
    ST_SEG,
    ST_DIST,
    ST_UU,
    ST_AT,
    ST_ROOT_SPD,
    ST_DONE
  } state_e;

endpackage

[hw/rtl/pspd_in_if.sv]
interface pspd_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [pspd_pkg::COORD_W-1:0]       x_coord;
  logic signed [pspd_pkg::COORD_W-1:0]       y_coord;
  logic                                      path_start;
  logic        [pspd_pkg::SPEED_W-1:0]       start_speed;

  modport source (output valid, x_coord, y_coord, path_start, start_speed, input ready);
  modport sink (input valid, x_coord, y_coord, path_start, start_speed, output ready);
endinterface

[hw/rtl/pspd_out_if.sv]
interface pspd_out_if;
  logic                          valid;
  logic                          ready;
  logic [pspd_pkg::SPEED_W-1:0]  speed;

  modport source (output valid, speed, input ready);
  modport sink (input valid, speed, output ready);
endinterface

[hw/rtl/pspd_cfg_if.sv]
interface pspd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pspd_pkg::CIDX_W-1:0]   index;
  logic [pspd_pkg::CFG_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/path_speed_profile.sv]
// speed profile along a path under constant acceleration
// pnt_i takes one path point per request (x, y in Q16.8 cells, path start flag,
// start speed); spd_o returns one Q4.12 speed per point, in order.
// cfg_i writes accel (0), max_speed (1) and map_resolution (2); it is always
// ready, and other indexes are dropped.
// a path start point goes straight to hand over and returns its start speed. any
// other point goes through one shared shift-add multiplier and bit-serial square
// root: the squares of both differences for the squared segment, its root, the
// scale to meters, the distance add, u*u + 2*a*d, the speed root and the hand
// over. the multiplier retires one multiplier bit and the root one result bit
// per cycle. one point is in work at a time: pnt_i is ready only when the
// sequencer is idle.
// the output register holds a finished speed while the receiver stalls; the
// next point is accepted meanwhile, and its result waits in the sequencer.
// reset restores the register defaults and clears the previous point, the
// travelled distance and the start speed.
module path_speed_profile (
  input logic        clk_i,
  input logic        rst_ni,
  pspd_in_if.sink    pnt_i,
  pspd_out_if.source spd_o,
  pspd_cfg_if.sink   cfg_i
);

  pspd_pkg::state_e state_q, state_d;

  logic [pspd_pkg::CFG_W-1:0]    accel_q, max_speed_q, map_res_q;
  logic [pspd_pkg::COORD_W-1:0]  prev_x_q, prev_y_q;
  logic [pspd_pkg::DIST_W-1:0]   trav_q, trav_d;
  logic [pspd_pkg::SPEED_W-1:0]  init_spd_q;
  logic [pspd_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          ovalid_q, ovalid_d;
  logic [pspd_pkg::SPEED_W-1:0]  speed_q, speed_d;

  logic [pspd_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [pspd_pkg::ACC_W-1:0]    mcand_q, mcand_d;
  logic [pspd_pkg::MPLIER_W-1:0] mplier_q, mplier_d;
  logic [pspd_pkg::ROOT_W-1:0]   root_q, root_d;
  logic [pspd_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [pspd_pkg::MPLIER_W-1:0] ay_q, ay_d;
  logic [pspd_pkg::SPEED_W-1:0]  res_q, res_d;

  logic                          in_fire, load_out, trav_we;
  logic signed [pspd_pkg::COORD_W:0] dx, dy;
  logic [pspd_pkg::MPLIER_W-1:0] ax, ay;
  logic [pspd_pkg::ACC_W-1:0]    mul_sum;
  logic [pspd_pkg::REM_W+1:0]    rem_sh, trial;
  logic                          root_ge;
  logic [pspd_pkg::DIST_W+1:0]   dist_sum;

  assign in_fire     = pnt_i.valid && pnt_i.ready;
  assign pnt_i.ready = (state_q == pspd_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign spd_o.valid = ovalid_q;
  assign spd_o.speed = speed_q;
  assign load_out    = (state_q == pspd_pkg::ST_DONE) && (!ovalid_q || spd_o.ready);

  // absolute coordinate differences
  always_comb begin
    dx = $signed({pnt_i.x_coord[pspd_pkg::COORD_W-1], pnt_i.x_coord})
       - $signed({prev_x_q[pspd_pkg::COORD_W-1], prev_x_q});
    dy = $signed({pnt_i.y_coord[pspd_pkg::COORD_W-1], pnt_i.y_coord})
       - $signed({prev_y_q[pspd_pkg::COORD_W-1], prev_y_q});
    ax = dx[pspd_pkg::COORD_W] ? pspd_pkg::MPLIER_W'(-dx) : pspd_pkg::MPLIER_W'(dx);
    ay = dy[pspd_pkg::COORD_W] ? pspd_pkg::MPLIER_W'(-dy) : pspd_pkg::MPLIER_W'(dy);
  end

  // shift-add step and square root step
  always_comb begin
    mul_sum = acc_q + (mplier_q[0] ? mcand_q : '0);
    rem_sh  = {rem_q, acc_q[pspd_pkg::ACC_W-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    root_ge = (rem_sh >= trial);
  end

  // distance update, saturating
  always_comb begin
    dist_sum = {2'b00, trav_q} + {1'b0, acc_q[40:8]};
    trav_d   = (dist_sum[pspd_pkg::DIST_W+1:pspd_pkg::DIST_W] != 2'b00)
             ? '1 : dist_sum[pspd_pkg::DIST_W-1:0];
    trav_we  = (state_q == pspd_pkg::ST_DIST);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pspd_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = pnt_i.path_start ? pspd_pkg::ST_DONE : pspd_pkg::ST_SQX;
        end
      end
      pspd_pkg::ST_SQX: begin
        if (cnt_q == pspd_pkg::CNT_SQ_LAST) state_d = pspd_pkg::ST_SQY;
      end
      pspd_pkg::ST_SQY: begin
        if (cnt_q == pspd_pkg::CNT_SQ_LAST) state_d = pspd_pkg::ST_ROOT_LEN;
      end
      pspd_pkg::ST_ROOT_LEN: begin
        if (cnt_q == pspd_pkg::CNT_ROOT_LAST) state_d = pspd_pkg::ST_SEG;
      end
      pspd_pkg::ST_SEG: begin
        if (cnt_q == pspd_pkg::CNT_MUL16_LAST) state_d = pspd_pkg::ST_DIST;
      end
      pspd_pkg::ST_DIST: state_d = pspd_pkg::ST_UU;
      pspd_pkg::ST_UU: begin
        if (cnt_q == pspd_pkg::CNT_MUL16_LAST) state_d = pspd_pkg::ST_AT;
      end
      pspd_pkg::ST_AT: begin
        if (cnt_q == pspd_pkg::CNT_MUL16_LAST) state_d = pspd_pkg::ST_ROOT_SPD;
      end
      pspd_pkg::ST_ROOT_SPD: begin
        if (cnt_q == pspd_pkg::CNT_ROOT_LAST) state_d = pspd_pkg::ST_DONE;
      end
      pspd_pkg::ST_DONE: begin
        if (load_out) state_d = pspd_pkg::ST_IDLE;
      end
      default: state_d = pspd_pkg::ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    root_d   = root_q;
    rem_d    = rem_q;
    ay_d     = ay_q;
    res_d    = res_q;
    cnt_d    = cnt_q + pspd_pkg::CNT_W'(1);
    ovalid_d = ovalid_q && !spd_o.ready;
    speed_d  = speed_q;
    unique case (state_q) inside
      pspd_pkg::ST_IDLE: begin
        cnt_d    = '0;
        acc_d    = '0;
        mcand_d  = pspd_pkg::ACC_W'(ax);
        mplier_d = ax;
        ay_d     = ay;
        res_d    = pnt_i.start_speed;
      end
      pspd_pkg::ST_SQX, pspd_pkg::ST_SQY, pspd_pkg::ST_SEG, pspd_pkg::ST_UU,
      pspd_pkg::ST_AT: begin
        acc_d    = mul_sum;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        if (state_q == pspd_pkg::ST_SQX && cnt_q == pspd_pkg::CNT_SQ_LAST) begin
          cnt_d    = '0;
          mcand_d  = pspd_pkg::ACC_W'(ay_q);
          mplier_d = ay_q;
        end else if (state_q == pspd_pkg::ST_SQY && cnt_q == pspd_pkg::CNT_SQ_LAST) begin
          cnt_d  = '0;
          root_d = '0;
          rem_d  = '0;
        end else if (state_q == pspd_pkg::ST_UU && cnt_q == pspd_pkg::CNT_MUL16_LAST) begin
          cnt_d    = '0;
          mcand_d  = pspd_pkg::ACC_W'(trav_q);
          mplier_d = pspd_pkg::MPLIER_W'(accel_q);
        end else if (state_q == pspd_pkg::ST_AT && cnt_q == pspd_pkg::CNT_MUL16_LAST) begin
          // drop the three fraction bits of 2*a*d
          cnt_d  = '0;
          acc_d  = mul_sum >> 3;
          root_d = '0;
          rem_d  = '0;
        end
      end
      pspd_pkg::ST_ROOT_LEN, pspd_pkg::ST_ROOT_SPD: begin
        acc_d  = acc_q << 2;
        rem_d  = root_ge ? pspd_pkg::REM_W'(rem_sh - trial) : rem_sh[pspd_pkg::REM_W-1:0];
        root_d = {root_q[pspd_pkg::ROOT_W-2:0], root_ge};
        if (state_q == pspd_pkg::ST_ROOT_LEN && cnt_q == pspd_pkg::CNT_ROOT_LAST) begin
          cnt_d    = '0;
          acc_d    = '0;
          mcand_d  = pspd_pkg::ACC_W'({root_q[pspd_pkg::ROOT_W-2:0], root_ge});
          mplier_d = pspd_pkg::MPLIER_W'(map_res_q);
        end
        if (state_q == pspd_pkg::ST_ROOT_SPD && cnt_q == pspd_pkg::CNT_ROOT_LAST) begin
          // clamp to the ceiling
          cnt_d = '0;
          res_d = ({root_q[pspd_pkg::ROOT_W-2:0], root_ge} > pspd_pkg::ROOT_W'(max_speed_q))
                ? max_speed_q : {root_q[pspd_pkg::SPEED_W-2:0], root_ge};
        end
      end
      pspd_pkg::ST_DIST: begin
        // u*u scaled by 8 to line up with a*d
        cnt_d    = '0;
        acc_d    = '0;
        mcand_d  = pspd_pkg::ACC_W'({init_spd_q, 3'b000});
        mplier_d = pspd_pkg::MPLIER_W'(init_spd_q);
      end
      pspd_pkg::ST_DONE: begin
        cnt_d = '0;
        if (load_out) begin
          ovalid_d = 1'b1;
          speed_d  = res_q;
        end
      end
      default: cnt_d = '0;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pspd_pkg::ST_IDLE;
      cnt_q       <= '0;
      ovalid_q    <= 1'b0;
      accel_q     <= pspd_pkg::ACCEL_RST;
      max_speed_q <= pspd_pkg::MAX_SPEED_RST;
      map_res_q   <= pspd_pkg::MAP_RES_RST;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      trav_q      <= '0;
      init_spd_q  <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          pspd_pkg::CFG_ACCEL:     accel_q     <= cfg_i.data;
          pspd_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_i.data;
          pspd_pkg::CFG_MAP_RES:   map_res_q   <= cfg_i.data;
          default: ;
        endcase
      end
      if (in_fire) begin
        prev_x_q <= pnt_i.x_coord;
        prev_y_q <= pnt_i.y_coord;
        if (pnt_i.path_start) begin
          trav_q     <= '0;
          init_spd_q <= pnt_i.start_speed;
        end
      end else if (trav_we) begin
        trav_q <= trav_d;
      end
    end
  end

  // serial datapath
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    root_q   <= root_d;
    rem_q    <= rem_d;
    ay_q     <= ay_d;
    res_q    <= res_d;
    speed_q  <= speed_d;
  end

  // checks
  a_busy_after_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !pnt_i.ready)
    else $error("point accepted while previous still in work");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pspd_pkg::CNT_ROOT_LAST)
    else $error("phase counter out of range");

  a_dist_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pspd_pkg::ST_DIST) |=> (trav_q >= $past(trav_q)))
    else $error("travelled distance decreased");

  a_root_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pspd_pkg::ST_ROOT_LEN || state_q == pspd_pkg::ST_ROOT_SPD) && cnt_q != '0)
      |-> (rem_q <= {1'b0, root_q, 1'b0}))
    else $error("square root remainder above bound");

  a_start_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && pnt_i.path_start) |=> (state_q == pspd_pkg::ST_DONE))
    else $error("path start point did not go straight to hand over");

endmodule
